>>> rtl/decimal_text_to_int64_macros.svh
// assertion macros shared by the checker
`ifndef DECIMAL_TEXT_TO_INT64_MACROS_SVH
`define DECIMAL_TEXT_TO_INT64_MACROS_SVH

// same-cycle implication, checked out of reset
`define DTOI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dtoi check failed");

// next-cycle implication, checked out of reset
`define DTOI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dtoi check failed");

`endif

>>> rtl/dtoi_pkg.sv
`timescale 1ns / 1ps
package dtoi_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_I     = 8'h69;
  localparam logic [7:0] CHAR_N     = 8'h6E;
  localparam logic [7:0] CHAR_F     = 8'h66;

  localparam logic [2:0]  INF_DONE   = 3'd3;
  localparam logic [2:0]  INF_FAILED = 3'd4;
  localparam logic [63:0] MAX_POS    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX_NEG    = 64'h8000_0000_0000_0001;

  typedef enum logic [1:0] {
    PH_SKIP    = 2'd0,
    PH_DIGITS  = 2'd1,
    PH_STOPPED = 2'd2
  } phase_e;

  // what the parser hands to the result register
  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
    logic        inf;
  } dtoi_res_t;

  function automatic logic [7:0] inf_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CHAR_I;
      2'd1:    c = CHAR_N;
      2'd2:    c = CHAR_F;
      default: c = CHAR_NUL;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/dtoi_parse.sv
`timescale 1ns / 1ps
module dtoi_parse
  import dtoi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output dtoi_res_t  res_o
);

  phase_e      phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic [2:0]  inf_q, inf_d;
  logic        term_q, term_d;

  always_comb begin
    phase_e     ph_b;
    logic       body;
    logic [3:0] digit;
    phase_d = phase_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    inf_d   = inf_q;
    term_d  = term_q;
    body    = 1'b0;
    ph_b    = phase_q;
    digit   = char_i[3:0];
    if (!term_q) begin
      if (phase_q == PH_SKIP) begin
        if (char_i >= 8'd1 && char_i <= CHAR_SPACE) begin
          body = 1'b0;
        end else if (char_i == CHAR_MINUS) begin
          neg_d   = 1'b1;
          phase_d = PH_DIGITS;
        end else if (char_i == CHAR_PLUS) begin
          phase_d = PH_DIGITS;
        end else begin
          phase_d = PH_DIGITS;
          ph_b    = PH_DIGITS;
          body    = 1'b1;
        end
      end else begin
        body = 1'b1;
      end
    end
    if (body) begin
      if (char_i == CHAR_NUL) begin
        term_d = 1'b1;
      end else begin
        if (inf_q < INF_DONE && char_i == inf_char(inf_q[1:0])) begin
          inf_d = inf_q + 3'd1;
        end else begin
          inf_d = INF_FAILED;
        end
        if (ph_b == PH_DIGITS) begin
          if (char_i >= CHAR_ZERO && char_i <= CHAR_NINE) begin
            // acc * 10 as acc * 8 + acc * 2
            acc_d = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} + {60'd0, digit};
          end else begin
            phase_d = PH_STOPPED;
          end
        end
      end
    end
    res_o.inf = (inf_d == INF_DONE);
    res_o.neg = neg_d;
    res_o.mag = (inf_d == INF_DONE) ? MAX_POS : acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      inf_q   <= '0;
      term_q  <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        // string done, back to the start for the next one
        phase_q <= PH_SKIP;
        acc_q   <= '0;
        neg_q   <= 1'b0;
        inf_q   <= '0;
        term_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        inf_q   <= inf_d;
        term_q  <= term_d;
      end
    end
  end

endmodule

>>> rtl/decimal_text_to_int64.sv
`timescale 1ns / 1ps
// decimal text to signed 64-bit integer. takes one character item per cycle,
// back to back, with tlast on the final character, and gives one result item
// (value, tuser = infinity flag) per string. the character stage holds one
// item and the result register holds one result, so the input stalls only
// when a final character meets a result not yet taken. a final character
// passes through the character stage and then the result register; the
// single 64-bit multiply-by-ten-and-add sits between the two registers.
module decimal_text_to_int64
  import dtoi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] char_code
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // [63:0] value
  output logic        m_axis_tuser_o   // [0] was_infinity
);

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       out_valid_q;
  dtoi_res_t  out_res_q;
  dtoi_res_t  res;
  logic       out_free;
  logic       advance;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;

  dtoi_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .char_i (in_char_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_res_q.neg ? (64'd0 - out_res_q.mag) : out_res_q.mag;
  assign m_axis_tuser_o  = out_res_q.inf;

endmodule

>>> rtl/dtoi_checker.sv
`timescale 1ns / 1ps
`include "decimal_text_to_int64_macros.svh"
module dtoi_checker
  import dtoi_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // an infinity result is always plus or minus the largest value
  `DTOI_ASSERT_NOW(a_inf_value, m_axis_tvalid_o && m_axis_tuser_o,
    m_axis_tdata_o == MAX_POS || m_axis_tdata_o == MAX_NEG)

  // the input only stalls behind a waiting result
  `DTOI_ASSERT_NOW(a_stall_cause, !s_axis_tready_o, m_axis_tvalid_o)

  // a result not taken stays offered
  `DTOI_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // a stalled character item stays offered until taken
  `DTOI_ASSERT_NEXT(a_in_hold, s_axis_tvalid_i && !s_axis_tready_o,
    s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tlast_i))

endmodule

bind decimal_text_to_int64 dtoi_checker u_dtoi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import dtoi_pkg::*;

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic [63:0] value;
    logic        inf;
  } parsed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'h00;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [63:0] m_data;
  logic        m_user;

  // sender and receiver idle enables, receiver hold-off in cycles
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int hold_left = 0;
  int err_count = 0;

  // parser state mirrored from the accepted character items
  phase_e      ps_phase = PH_SKIP;
  logic [63:0] ps_acc = '0;
  logic        ps_neg = 1'b0;
  logic [2:0]  ps_inf = '0;
  logic        ps_term = 1'b0;
  parsed_t     parsed_q[$];

  const logic [7:0] INF_WORD [3] = '{CHAR_I, CHAR_N, CHAR_F};

  decimal_text_to_int64 uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  always #6 clk = ~clk;

  task automatic clear_parse();
    ps_phase = PH_SKIP;
    ps_acc   = '0;
    ps_neg   = 1'b0;
    ps_inf   = '0;
    ps_term  = 1'b0;
  endtask

  // a character after the leading space and the sign
  task automatic parse_body(input logic [7:0] c);
    if (c == CHAR_NUL) begin
      ps_term = 1'b1;
    end else begin
      if (ps_inf < INF_DONE && c == INF_WORD[ps_inf[1:0]]) ps_inf = ps_inf + 3'd1;
      else ps_inf = INF_FAILED;
      if (ps_phase == PH_DIGITS) begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) ps_acc = ps_acc * 64'd10 + 64'(c - CHAR_ZERO);
        else ps_phase = PH_STOPPED;
      end
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic last);
    parsed_t r;
    if (!ps_term) begin
      if (ps_phase == PH_SKIP) begin
        if (c >= 8'd1 && c <= CHAR_SPACE) begin
          // leading space, skipped
        end else if (c == CHAR_MINUS) begin
          ps_neg   = 1'b1;
          ps_phase = PH_DIGITS;
        end else if (c == CHAR_PLUS) begin
          ps_phase = PH_DIGITS;
        end else begin
          ps_phase = PH_DIGITS;
          parse_body(c);
        end
      end else begin
        parse_body(c);
      end
    end
    if (last) begin
      if (ps_inf == INF_DONE) begin
        r.value = ps_neg ? 64'd0 - MAX_POS : MAX_POS;
        r.inf   = 1'b1;
      end else begin
        r.value = ps_neg ? 64'd0 - ps_acc : ps_acc;
        r.inf   = 1'b0;
      end
      parsed_q.push_back(r);
      clear_parse();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && s_valid && s_ready) parse_char(s_data, s_last);
  end

  always @(posedge clk) begin
    parsed_t want;
    if (rst_n && m_valid && m_ready) begin
      if (parsed_q.size() == 0) begin
        $error("unexpected result item: value %0d inf %0b", $signed(m_data), m_user);
        err_count++;
      end else begin
        want = parsed_q.pop_front();
        if (m_data !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), $signed(m_data));
          err_count++;
        end
        if (m_user !== want.inf) begin
          $error("was_infinity: expected %0b, got %0b", want.inf, m_user);
          err_count++;
        end
      end
    end
  end

  // receiver: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_ready   <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_ready <= !(rx_gaps && $urandom_range(99) < 38);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    @(negedge clk);
    while (tx_gaps && $urandom_range(99) < 38) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= c;
    s_last  <= last;
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic send_text(input char_q_t t);
    foreach (t[i]) send_char(t[i], i == t.size() - 1);
  endtask

  function automatic char_q_t to_chars(input string s);
    char_q_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    s_valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic char_q_t random_text();
    char_q_t t;
    int kind;
    int len;
    repeat ($urandom_range(0, 2)) t.push_back(8'($urandom_range(1, 32)));
    case ($urandom_range(3))
      0: t.push_back(CHAR_MINUS);
      1: t.push_back(CHAR_PLUS);
      default: ;
    endcase
    if ($urandom_range(19) == 0) t.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
    kind = $urandom_range(99);
    if (kind < 60) begin
      len = ($urandom_range(8) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 8);
      repeat (len) t.push_back(CHAR_ZERO + 8'($urandom_range(9)));
    end else if (kind < 72) begin
      len = $urandom_range(3) == 0 ? $urandom_range(1, 2) : 3;
      for (int i = 0; i < len; i++) t.push_back(INF_WORD[i]);
      if ($urandom_range(3) == 0) t.push_back(8'($urandom_range(255)));
    end else if (kind < 86) begin
      repeat ($urandom_range(1, 5)) t.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      repeat ($urandom_range(1, 4)) t.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(255)));
    end
    // early terminator with trailing bytes that must be ignored
    if ($urandom_range(9) == 0) begin
      t.push_back(CHAR_NUL);
      repeat ($urandom_range(0, 3)) t.push_back(8'($urandom_range(255)));
    end
    if (t.size() == 0) t.push_back(8'($urandom_range(255)));
    return t;
  endfunction

  task automatic test_directed();
    send_text(to_chars(" -inf"));
    send_text(to_chars("inf"));
    send_text(to_chars("+-5"));
    send_text('{8'h37, CHAR_NUL, 8'hFF});
    send_text(to_chars("-"));
    send_text(to_chars("99999999999999999999"));
    wait_drained();
  endtask

  task automatic test_full_rate();
    int sent;
    sent = 0;
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    while (sent < 80) begin
      char_q_t t;
      t = random_text();
      send_text(t);
      sent += t.size();
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    @(negedge clk);
    hold_left = 200;
    // short strings so results pile up and the input stalls
    for (int i = 0; i < 10; i++) send_char(CHAR_ZERO + 8'(i), 1'b1);
    send_text(to_chars("-12"));
    tx_gaps = 1'b1;
    wait_drained();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 650) begin
      char_q_t t;
      t = random_text();
      send_text(t);
      sent += t.size();
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_rate();
    test_backpressure();
    test_random();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS decimal_text_to_int64");
    end else begin
      $display("FAIL decimal_text_to_int64");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL decimal_text_to_int64");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/dtoi_pkg.sv
rtl/dtoi_parse.sv
rtl/decimal_text_to_int64.sv
rtl/dtoi_checker.sv
tb/sv/tb.sv
